// File: rtl/interval_set_table_defines.svh
// assertion macros used by the checker
`ifndef INTERVAL_SET_TABLE_DEFINES_SVH
`define INTERVAL_SET_TABLE_DEFINES_SVH

// same-cycle implication
`define IST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ist_pkg.sv
package ist_pkg;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_SECOND,
      ST_FINISH
   } ist_state_type;

endpackage

// File: rtl/ist_ram.sv
module ist_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/interval_set_table.sv
// channel  | ports                                          | dir
// req      | req_valid req_ready req_mode req_range_start/end | in
// rsp      | rsp_valid rsp_ready rsp_covered rsp_status       | out
//          | rsp_entries_used                               |
// Per request: each stored entry is read (SCAN) and evaluated (EVAL); an add that
// inserts mid-table or a remove that splits adds a second write (SECOND). An empty range
// or unused mode goes straight to FINISH; FINISH then returns to IDLE. Two-port table RAM.
// Two banks: the new table is built in the idle bank and swapped in on success.
// Synchronous reset empties the table at once; no clearing pass.
// A new word is accepted while a result waits; a stalled result holds the finish.
module interval_set_table #(
   parameter int CAPACITY   = 16,
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_covered,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_entries_used
);

   localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW = $clog2(CAPACITY + 1);
   localparam int AW = IW + 1;
   localparam int DEPTH = 2 ** AW;
   localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

   ist_pkg::ist_state_type state_ff, state_in;

   logic [1:0]      mode_ff, mode_in;
   logic [CW-1:0]   s_ff, s_in, e_ff, e_in;
   logic [CW-1:0]   ms_ff, ms_in, me_ff, me_in;
   logic [NW-1:0]   idx_ff, idx_in, n_ff, n_in, used_ff, used_in;
   logic            bank_ff, bank_in;
   logic            placed_ff, placed_in, ovf_ff, ovf_in, cov_ff, cov_in;
   logic            skip_ff, skip_in;
   logic [1:0]      skip_status_ff, skip_status_in;
   logic [2*CW-1:0] pend_ff, pend_in;

   logic            rsp_valid_ff, rsp_valid_in, rsp_cov_ff, rsp_cov_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [4:0]      rsp_used_ff, rsp_used_in;

   logic [CW-1:0]   req_s, req_e;
   logic            req_skip;

   logic [CW-1:0]   ent_a, ent_b;
   logic [1:0]      ev_k;
   logic [2*CW-1:0] ev_w0, ev_w1;
   logic [CW-1:0]   ev_ms, ev_me;
   logic            ev_placed, ev_cov;

   logic            finish_go, tail, ovf_final;
   logic [NW-1:0]   n_final;
   logic            wr_req;
   logic [2*CW-1:0] wr_word;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [2*CW-1:0] ram_rdata;

   ist_ram #(
      .DEPTH (DEPTH),
      .WIDTH (2 * CW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_word),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_s    = req_range_start[CW-1:0];
   assign req_e    = req_range_end[CW-1:0];
   assign req_skip = (req_mode == ist_pkg::MODE_NOP) || (req_s >= req_e);

   assign ent_a = ram_rdata[2*CW-1:CW];
   assign ent_b = ram_rdata[CW-1:0];

   assign finish_go = !rsp_valid_ff || rsp_ready;
   assign tail      = (mode_ff == ist_pkg::MODE_ADD) && !placed_ff && !skip_ff;
   assign ovf_final = ovf_ff || (tail && (n_ff == CAP_N));
   assign n_final   = (tail && !ovf_final) ? n_ff + NW'(1) : n_ff;

   // per-entry evaluation
   always_comb begin
      ev_k      = 2'd0;
      ev_w0     = {ent_a, ent_b};
      ev_w1     = {ent_a, ent_b};
      ev_ms     = ms_ff;
      ev_me     = me_ff;
      ev_placed = placed_ff;
      ev_cov    = cov_ff;
      unique case (mode_ff)
         ist_pkg::MODE_ADD: begin
            if (ent_b < s_ff) begin
               ev_k = 2'd1;
            end else if (ent_a <= e_ff) begin
               if (ent_a < ms_ff) ev_ms = ent_a;
               if (ent_b > me_ff) ev_me = ent_b;
            end else if (!placed_ff) begin
               ev_k      = 2'd2;
               ev_w0     = {ms_ff, me_ff};
               ev_placed = 1'b1;
            end else begin
               ev_k = 2'd1;
            end
         end
         ist_pkg::MODE_REMOVE: begin
            if ((ent_b <= s_ff) || (ent_a >= e_ff)) begin
               ev_k = 2'd1;
            end else if ((ent_a < s_ff) && (ent_b > e_ff)) begin
               ev_k  = 2'd2;
               ev_w0 = {ent_a, s_ff};
               ev_w1 = {e_ff, ent_b};
            end else if (ent_a < s_ff) begin
               ev_k  = 2'd1;
               ev_w0 = {ent_a, s_ff};
            end else if (ent_b > e_ff) begin
               ev_k  = 2'd1;
               ev_w0 = {e_ff, ent_b};
            end
         end
         ist_pkg::MODE_QUERY: begin
            if ((ent_a <= s_ff) && (e_ff <= ent_b)) ev_cov = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ist_pkg::ST_IDLE: begin
            if (req_valid) state_in = req_skip ? ist_pkg::ST_FINISH : ist_pkg::ST_SCAN;
         end
         ist_pkg::ST_SCAN: begin
            state_in = (idx_ff == used_ff) ? ist_pkg::ST_FINISH : ist_pkg::ST_EVAL;
         end
         ist_pkg::ST_EVAL: begin
            state_in = (ev_k == 2'd2) ? ist_pkg::ST_SECOND : ist_pkg::ST_SCAN;
         end
         ist_pkg::ST_SECOND: begin
            state_in = ist_pkg::ST_SCAN;
         end
         ist_pkg::ST_FINISH: begin
            if (finish_go) state_in = ist_pkg::ST_IDLE;
         end
         default: begin
            state_in = ist_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      mode_in        = mode_ff;
      s_in           = s_ff;
      e_in           = e_ff;
      ms_in          = ms_ff;
      me_in          = me_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      used_in        = used_ff;
      bank_in        = bank_ff;
      placed_in      = placed_ff;
      ovf_in         = ovf_ff;
      cov_in         = cov_ff;
      skip_in        = skip_ff;
      skip_status_in = skip_status_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_cov_in     = rsp_cov_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_used_in    = rsp_used_ff;
      wr_req         = 1'b0;
      wr_word        = ev_w0;
      ram_re         = 1'b0;
      ram_raddr      = {bank_ff, idx_ff[IW-1:0]};
      ram_we         = 1'b0;
      ram_waddr      = {!bank_ff, n_ff[IW-1:0]};

      unique case (state_ff)
         ist_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in        = req_mode;
               s_in           = req_s;
               e_in           = req_e;
               ms_in          = req_s;
               me_in          = req_e;
               idx_in         = '0;
               n_in           = '0;
               placed_in      = 1'b0;
               ovf_in         = 1'b0;
               cov_in         = 1'b0;
               skip_in        = req_skip;
               skip_status_in = (req_mode == ist_pkg::MODE_NOP) ?
                                ist_pkg::STATUS_DONE : ist_pkg::STATUS_EMPTY;
            end
         end
         ist_pkg::ST_SCAN: begin
            ram_re = (idx_ff != used_ff);
         end
         ist_pkg::ST_EVAL: begin
            idx_in    = idx_ff + NW'(1);
            ms_in     = ev_ms;
            me_in     = ev_me;
            placed_in = ev_placed;
            cov_in    = ev_cov;
            pend_in   = ev_w1;
            wr_req    = (ev_k != 2'd0);
            wr_word   = ev_w0;
         end
         ist_pkg::ST_SECOND: begin
            wr_req  = 1'b1;
            wr_word = pend_ff;
         end
         ist_pkg::ST_FINISH: begin
            if (finish_go) begin
               wr_req       = tail;
               wr_word      = {ms_ff, me_ff};
               rsp_valid_in = 1'b1;
               rsp_cov_in   = 1'b0;
               rsp_status_in = ist_pkg::STATUS_DONE;
               rsp_used_in  = 5'(used_ff);
               if (skip_ff) begin
                  rsp_status_in = skip_status_ff;
               end else if (mode_ff == ist_pkg::MODE_QUERY) begin
                  rsp_cov_in = cov_ff;
               end else if (ovf_final) begin
                  rsp_status_in = ist_pkg::STATUS_FULL;
               end else begin
                  bank_in     = !bank_ff;
                  used_in     = n_final;
                  rsp_used_in = 5'(n_final);
               end
            end
         end
         default: begin
         end
      endcase

      if (wr_req) begin
         if (n_ff == CAP_N) begin
            ovf_in = 1'b1;
         end else begin
            ram_we = 1'b1;
            n_in   = n_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ist_pkg::ST_IDLE;
         used_ff      <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      s_ff           <= s_in;
      e_ff           <= e_in;
      ms_ff          <= ms_in;
      me_ff          <= me_in;
      idx_ff         <= idx_in;
      n_ff           <= n_in;
      placed_ff      <= placed_in;
      ovf_ff         <= ovf_in;
      cov_ff         <= cov_in;
      skip_ff        <= skip_in;
      skip_status_ff <= skip_status_in;
      pend_ff        <= pend_in;
      rsp_cov_ff     <= rsp_cov_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_covered      = rsp_cov_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entries_used = rsp_used_ff;

endmodule

// File: rtl/ist_checker.sv
`include "interval_set_table_defines.svh"

module ist_checker #(
   parameter int CAPACITY = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_covered,
   input logic [1:0] rsp_status,
   input logic [4:0] rsp_entries_used
);

   `IST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_covered) && $stable(rsp_status) && $stable(rsp_entries_used), "stalled rsp word changed")
   `IST_ASSERT_NOW(a_used_bound, clock, reset, rsp_valid, (CAPACITY > 31) || (rsp_entries_used <= CAPACITY), "entries_used above capacity")
   `IST_ASSERT_NOW(a_cov_done, clock, reset, rsp_valid && rsp_covered, rsp_status == ist_pkg::STATUS_DONE, "covered with non-done status")
   `IST_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && req_ready, "reset did not clear the block")
   `IST_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready during item processing")

endmodule

bind interval_set_table ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CAP         = 16;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic       covered;
      logic [1:0] status;
      logic [4:0] entries_used;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = ist_pkg::MODE_ADD;
   logic [31:0] req_range_start = '0;
   logic [31:0] req_range_end = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_covered;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_entries_used;

   // predicted interval set
   logic [31:0] set_starts [CAP];
   logic [31:0] set_ends [CAP];
   int          set_count = 0;

   rsp_word_type pending_results [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          tx_gap_pct = 0;
   int          rx_stall_pct = 0;
   int          rx_hold_cycles = 0;
   int          rx_stall_left = 0;
   logic [31:0] coord_base = '0;
   int          coord_span = 128;

   interval_set_table i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_covered      (rsp_covered),
      .rsp_status       (rsp_status),
      .rsp_entries_used (rsp_entries_used)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_word_type apply_interval_op(input logic [1:0] mode,
                                                     input logic [31:0] s,
                                                     input logic [31:0] e);
      logic [31:0] ns [CAP + 2];
      logic [31:0] ne [CAP + 2];
      logic [31:0] ms;
      logic [31:0] me;
      int          n;
      bit          placed;
      rsp_word_type r;
      r = '0;
      n = 0;
      placed = 1'b0;
      ms = s;
      me = e;
      if (mode != ist_pkg::MODE_NOP) begin
         if (s >= e) begin
            r.status = ist_pkg::STATUS_EMPTY;
         end else begin
            case (mode)
               ist_pkg::MODE_ADD: begin
                  for (int i = 0; i < set_count; i++) begin
                     if (set_ends[i] >= s && set_starts[i] <= e) begin
                        if (set_starts[i] < ms) ms = set_starts[i];
                        if (set_ends[i] > me) me = set_ends[i];
                     end
                  end
                  for (int i = 0; i < set_count; i++) begin
                     if (set_ends[i] < s) begin
                        ns[n] = set_starts[i]; ne[n] = set_ends[i]; n++;
                     end else if (set_starts[i] > e) begin
                        if (!placed) begin
                           ns[n] = ms; ne[n] = me; n++;
                           placed = 1'b1;
                        end
                        ns[n] = set_starts[i]; ne[n] = set_ends[i]; n++;
                     end
                  end
                  if (!placed) begin
                     ns[n] = ms; ne[n] = me; n++;
                  end
               end
               ist_pkg::MODE_REMOVE: begin
                  // at most one interval can be split, so n stays within CAP + 1
                  for (int i = 0; i < set_count; i++) begin
                     if (set_ends[i] <= s || set_starts[i] >= e) begin
                        ns[n] = set_starts[i]; ne[n] = set_ends[i]; n++;
                     end else begin
                        if (set_starts[i] < s) begin
                           ns[n] = set_starts[i]; ne[n] = s; n++;
                        end
                        if (set_ends[i] > e) begin
                           ns[n] = e; ne[n] = set_ends[i]; n++;
                        end
                     end
                  end
               end
               default: begin
                  for (int i = 0; i < set_count; i++) begin
                     if (set_starts[i] <= s && e <= set_ends[i]) r.covered = 1'b1;
                  end
               end
            endcase
            if (mode == ist_pkg::MODE_ADD || mode == ist_pkg::MODE_REMOVE) begin
               if (n > CAP) begin
                  r.status = ist_pkg::STATUS_FULL;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     set_starts[i] = ns[i];
                     set_ends[i] = ne[i];
                  end
                  set_count = n;
               end
            end
         end
      end
      r.entries_used = 5'(set_count);
      return r;
   endfunction

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_word(input logic [1:0] mode, input logic [31:0] s,
                            input logic [31:0] e);
      int gap;
      gap = pick_gap(tx_gap_pct);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_range_start <= s;
      req_range_end <= e;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      pending_results.push_back(apply_interval_op(mode, s, e));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word", 32'({rsp_covered, rsp_status,
                            rsp_entries_used}), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_covered !== want.covered)
               report_mismatch("covered", 32'(rsp_covered), 32'(want.covered));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_entries_used !== want.entries_used)
               report_mismatch("entries_used", 32'(rsp_entries_used),
                               32'(want.entries_used));
         end
      end
   end

   // receiver: long hold-off on request, else random stalls
   always @(negedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_cycles = rx_hold_cycles - 1;
      end else if (rx_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left = rx_stall_left - 1;
      end else begin
         rx_stall_left = pick_gap(rx_stall_pct);
         if (rx_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** interval_set_table: FAILED **");
         $finish;
      end
   end

   task automatic test_empty_and_unused();
      send_word(ist_pkg::MODE_ADD, 32'd100, 32'd100);
      send_word(ist_pkg::MODE_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(ist_pkg::MODE_REMOVE, 32'd5, 32'd6);
      send_word(ist_pkg::MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_for_results();
   endtask

   task automatic test_coordinate_extremes();
      send_word(ist_pkg::MODE_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(ist_pkg::MODE_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(ist_pkg::MODE_REMOVE, 32'h0000_0001, 32'hFFFF_FFFE);
      send_word(ist_pkg::MODE_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
      wait_for_results();
   endtask

   task automatic test_full_table();
      for (int k = 0; k < CAP; k++)
         send_word(ist_pkg::MODE_ADD, 32'(k * 8), 32'(k * 8 + 4));
      send_word(ist_pkg::MODE_ADD, 32'd1000, 32'd1001);
      // strictly inside the first interval: needs a free entry
      send_word(ist_pkg::MODE_REMOVE, 32'd1, 32'd2);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      tx_gap_pct = 0;
      rx_stall_pct = 0;
      rx_hold_cycles = 300;
      for (int k = 0; k < 12; k++)
         send_word(k % 3 == 0 ? ist_pkg::MODE_QUERY : ist_pkg::MODE_ADD,
                   32'(2000 + k * 3), 32'(2001 + k * 3));
      wait_for_results();
   endtask

   task automatic send_random_op();
      int          pick;
      int          k;
      logic [1:0]  mode;
      logic [31:0] s;
      logic [31:0] e;
      pick = $urandom_range(99);
      if (pick < 42) mode = ist_pkg::MODE_ADD;
      else if (pick < 68) mode = ist_pkg::MODE_REMOVE;
      else if (pick < 97) mode = ist_pkg::MODE_QUERY;
      else mode = ist_pkg::MODE_NOP;
      if ($urandom_range(19) == 0) begin
         s = $urandom;
         e = $urandom;
      end else if (mode == ist_pkg::MODE_QUERY && set_count > 0 &&
                   $urandom_range(1) == 1) begin
         // sub-range of a stored interval, sometimes with its end moved up by one
         k = $urandom_range(set_count - 1);
         s = set_starts[k] + ($urandom % (set_ends[k] - set_starts[k]));
         e = s + 32'd1 + ($urandom % (set_ends[k] - s));
         if ($urandom_range(3) == 0) e = e + 32'd1;
      end else begin
         s = coord_base + $urandom_range(coord_span);
         e = s + $urandom_range(1, coord_span / 6 + 1);
         if ($urandom_range(24) == 0) e = s - $urandom_range(2);
      end
      send_word(mode, s, e);
   endtask

   task automatic test_random_traffic(input int n_items, input logic [31:0] base,
                                      input int span, input int gap_pct,
                                      input int stall_pct);
      coord_base = base;
      coord_span = span;
      tx_gap_pct = gap_pct;
      rx_stall_pct = stall_pct;
      send_word(ist_pkg::MODE_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
      repeat (n_items) send_random_op();
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_gap_pct = 25;
      rx_stall_pct = 25;
      test_empty_and_unused();
      test_coordinate_extremes();
      test_full_table();
      test_backpressure();
      test_random_traffic(300, 32'h0000_0000, 120, 30, 30);
      test_random_traffic(300, $urandom, 400, 0, 0);
      test_random_traffic(300, 32'hFFFF_FF00, 200, 30, 0);
      test_random_traffic(300, 32'h0000_1000, 160, 0, 40);

      wait_for_results();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("** interval_set_table: PASSED **");
      end else begin
         $display("** interval_set_table: FAILED **");
      end
      $finish;
   end

endmodule

// File: interval_set_table.f
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_ram.sv
rtl/interval_set_table.sv
rtl/ist_checker.sv
bench/testbench.sv
